FILE: design/bqlpf_pkg.sv
// ----------------------------------------------------------------------------
// bqlpf_pkg
// Shared widths, formats and register indexes for the biquad low-pass filter.
// ----------------------------------------------------------------------------
package bqlpf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;
  localparam int HIST_FRAC = 20;
  localparam int HIST_W    = SAMPLE_W + 4 + HIST_FRAC;
  localparam int ACC_W     = 56;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ON = 3'd0,
    REG_COEF_B0   = 3'd1,
    REG_COEF_B1   = 3'd2,
    REG_COEF_B2   = 3'd3,
    REG_COEF_A1   = 3'd4,
    REG_COEF_A2   = 3'd5
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< COEF_FRAC);

endpackage

FILE: design/biquad_lowpass_filter.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Direct form I biquad with programmable Q4.28 coefficients, round-to-even
// output, saturating Q20.20 output history and a pass-through mode.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled; each sample
// passes the input register, then the result register. The rate is set by
// the feedback path: the previous output feeds the next sample's multiply and
// sum combinationally, through seven parallel multipliers of at most 21 x 32
// bits, the 40-bit history being split into a signed high part and an
// unsigned low part. Coefficient and mode writes must be made only while no
// transaction is in flight.
module biquad_lowpass_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic        in_tuser,   // [0] start_of_sound
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int SW   = bqlpf_pkg::SAMPLE_W;
  localparam int CW   = bqlpf_pkg::COEF_W;
  localparam int CF   = bqlpf_pkg::COEF_FRAC;
  localparam int HF   = bqlpf_pkg::HIST_FRAC;
  localparam int HW   = bqlpf_pkg::HIST_W;
  localparam int AW   = bqlpf_pkg::ACC_W;
  localparam int HHW  = HW - HF;
  localparam int PFW  = SW + CW;
  localparam int PHW  = HHW + CW;
  localparam int PLW  = HF + 1 + CW;
  localparam int LOWW = PLW + 1;
  localparam int FBW  = LOWW;
  localparam int LIMB = SW + 3 + CF;
  localparam int HCW  = LIMB + 1;
  localparam int SH   = CF - HF;
  localparam int OQW  = AW - CF;

  localparam logic signed [OQW:0]  OUT_MAX = (OQW+1)'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [OQW:0]  OUT_MIN = (OQW+1)'(-(64'sd1 <<< (SW - 1)));
  localparam logic signed [HW-1:0] HIST_MAX = {1'b0, {(HW-1){1'b1}}};

  logic                 s1_valid_r;
  logic signed [SW-1:0] s1_sample_r;
  logic                 s1_start_r;
  logic                 out_tvalid_r;
  logic [SW-1:0]        out_data_r;
  logic                 adv;

  logic                 filter_on_r;
  logic signed [CW-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic signed [SW-1:0] prev_in_1_r, prev_in_2_r;
  logic signed [HW-1:0] prev_out_1_r, prev_out_2_r;

  logic signed [SW-1:0]  pi1, pi2;
  logic signed [HW-1:0]  po1, po2;
  logic signed [HHW-1:0] h1, h2;
  logic signed [HF:0]    l1, l2;
  logic signed [PFW-1:0] p_b0, p_b1, p_b2;
  logic signed [PHW-1:0] p_h1, p_h2;
  logic signed [PLW-1:0] p_l1, p_l2;
  logic signed [LOWW-1:0] low;
  logic signed [FBW-1:0] fb;
  logic signed [AW-1:0]  acc;

  logic signed [OQW-1:0] oq;
  logic                  oinc;
  logic signed [OQW:0]   orv;
  logic [SW-1:0]         sample_out_nxt;

  logic                  hovf;
  logic signed [HCW-1:0] hc;
  logic signed [HW-1:0]  hq;
  logic                  hinc;
  logic signed [HW-1:0]  hist_nxt;

  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // history as seen by this sample
  assign pi1 = s1_start_r ? '0 : prev_in_1_r;
  assign pi2 = s1_start_r ? '0 : prev_in_2_r;
  assign po1 = s1_start_r ? '0 : prev_out_1_r;
  assign po2 = s1_start_r ? '0 : prev_out_2_r;

  assign h1 = po1[HW-1:HF];
  assign h2 = po2[HW-1:HF];
  assign l1 = {1'b0, po1[HF-1:0]};
  assign l2 = {1'b0, po2[HF-1:0]};

  assign p_b0 = s1_sample_r * coef_b0_r;
  assign p_b1 = pi1 * coef_b1_r;
  assign p_b2 = pi2 * coef_b2_r;
  assign p_h1 = h1 * coef_a1_r;
  assign p_h2 = h2 * coef_a2_r;
  assign p_l1 = l1 * coef_a1_r;
  assign p_l2 = l2 * coef_a2_r;

  assign low = p_l1 + p_l2;
  assign fb  = p_h1 + p_h2 + $signed(low[LOWW-1:HF]);
  assign acc = p_b0 + p_b1 + p_b2 - fb;

  // output: round half to even, saturate
  assign oq   = acc[AW-1:CF];
  assign oinc = acc[CF-1] & ((|acc[CF-2:0]) | acc[CF]);
  assign orv  = {oq[OQW-1], oq} + {{OQW{1'b0}}, oinc};

  always_comb begin
    if (orv > OUT_MAX) begin
      sample_out_nxt = OUT_MAX[SW-1:0];
    end else if (orv < OUT_MIN) begin
      sample_out_nxt = OUT_MIN[SW-1:0];
    end else begin
      sample_out_nxt = orv[SW-1:0];
    end
  end

  // history: clamp accumulator, round half to even, clamp to history range
  assign hovf = !((&acc[AW-1:LIMB]) || !(|acc[AW-1:LIMB]));
  assign hc   = hovf ? (acc[AW-1] ? {1'b1, {LIMB{1'b0}}} : {1'b0, {LIMB{1'b1}}})
                     : acc[HCW-1:0];
  assign hq   = hc[HCW-1:SH];
  assign hinc = hc[SH-1] & ((|hc[SH-2:0]) | hc[SH]);
  assign hist_nxt = (hinc && (hq != HIST_MAX)) ? hq + HW'(1) : hq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      filter_on_r  <= 1'b0;
      coef_b0_r    <= bqlpf_pkg::COEF_ONE;
      coef_b1_r    <= '0;
      coef_b2_r    <= '0;
      coef_a1_r    <= '0;
      coef_a2_r    <= '0;
      prev_in_1_r  <= '0;
      prev_in_2_r  <= '0;
      prev_out_1_r <= '0;
      prev_out_2_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (in_tvalid && in_tready) begin
        s1_sample_r <= in_tdata;
        s1_start_r  <= in_tuser;
      end
      if (adv) begin
        out_tvalid_r <= s1_valid_r;
      end
      if (s1_valid_r && adv) begin
        if (filter_on_r) begin
          out_data_r   <= sample_out_nxt;
          prev_in_2_r  <= pi1;
          prev_in_1_r  <= s1_sample_r;
          prev_out_2_r <= po1;
          prev_out_1_r <= hist_nxt;
        end else begin
          out_data_r <= s1_sample_r;
          if (s1_start_r) begin
            prev_in_1_r  <= '0;
            prev_in_2_r  <= '0;
            prev_out_1_r <= '0;
            prev_out_2_r <= '0;
          end
        end
      end
      if (cfg_we) begin
        case (bqlpf_pkg::cfg_reg_t'(cfg_index))
          bqlpf_pkg::REG_FILTER_ON: filter_on_r <= cfg_wdata[0];
          bqlpf_pkg::REG_COEF_B0:   coef_b0_r   <= cfg_wdata;
          bqlpf_pkg::REG_COEF_B1:   coef_b1_r   <= cfg_wdata;
          bqlpf_pkg::REG_COEF_B2:   coef_b2_r   <= cfg_wdata;
          bqlpf_pkg::REG_COEF_A1:   coef_a1_r   <= cfg_wdata;
          bqlpf_pkg::REG_COEF_A2:   coef_a2_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register is free");

  a_start_clears_history: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && s1_start_r && !filter_on_r) |=>
      (prev_in_1_r == '0 && prev_in_2_r == '0 &&
       prev_out_1_r == '0 && prev_out_2_r == '0))
    else $error("start of sound did not clear history");

  a_bypass_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && !filter_on_r) |=>
      (out_tvalid && out_tdata == $past(s1_sample_r)))
    else $error("bypass result differs from input sample");

  a_bypass_keeps_feedback: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && !filter_on_r && !s1_start_r) |=>
      $stable(prev_out_1_r) && $stable(prev_out_2_r))
    else $error("history changed while filter is off");

endmodule
